/* src/a85_pkg.sv */
`default_nettype none
package a85_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} a85_in_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} a85_out_t;

	localparam int unsigned DIGIT_COUNT = 5;

	// one unit of work for the character emitter; digits[0] is most significant
	typedef struct packed {
		logic                         open_delim;
		logic                         zero_group;
		logic [2:0]                   ndig;
		logic [DIGIT_COUNT-1:0][6:0]  digits;
		logic                         close_delim;
	} a85_job_t;

	typedef enum logic [2:0] {
		EM_IDLE,
		EM_OPEN0,
		EM_OPEN1,
		EM_BODY,
		EM_CLOSE0,
		EM_CLOSE1
	} a85_emit_state_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] DIGIT_BIAS = 8'd33;

	localparam logic [2:0] NDIG_FULL  = 3'd5;
	localparam logic [2:0] CONV_STEPS = 3'd4;

	// floor(x / 85) == (x * RECIP85) >> RECIP85_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP85       = 32'hC0C0C0C1;
	localparam int unsigned RECIP85_SHIFT = 38;
	localparam logic [6:0]  RADIX         = 7'd85;

	function automatic a85_emit_state_t after_body(input a85_job_t j);
		return j.close_delim ? EM_CLOSE0 : EM_IDLE;
	endfunction

	function automatic a85_emit_state_t after_open(input a85_job_t j);
		return (j.zero_group || (j.ndig != 3'd0)) ? EM_BODY : after_body(j);
	endfunction

	function automatic a85_emit_state_t first_state(input a85_job_t j);
		return j.open_delim ? EM_OPEN0 : after_open(j);
	endfunction

endpackage
`default_nettype wire

/* src/a85_front.sv */
`default_nettype none
module a85_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  a85_pkg::a85_in_t    in_data,
	output logic                job_valid,
	input  wire                 job_ready,
	output a85_pkg::a85_job_t   job
);
	import a85_pkg::*;

	// group accumulator
	logic [23:0] word_q;
	logic [1:0]  fill_q;
	logic        inside_q;

	// base-85 converter
	logic        conv_valid_q;
	logic [2:0]  steps_q;
	logic [31:0] x_q;
	logic [6:0]  dig_q [4];
	logic        conv_open_q;
	logic        conv_zero_q;
	logic [2:0]  conv_ndig_q;
	logic        conv_close_q;

	logic        open_req, completes, need_job, accept, load_conv;
	logic        conv_push, conv_free, conv_step;
	logic [31:0] full_word, padded, req_word;
	logic [2:0]  req_ndig;
	logic        req_zero;
	logic [63:0] prod;
	logic [25:0] quot;
	logic [6:0]  quot85_lo, rem;
	logic [1:0]  dig_idx;

	always_comb begin
		open_req  = !inside_q;
		completes = (fill_q == 2'd3);
		need_job  = open_req || completes || in_data.end_of_message;
		full_word = {word_q, in_data.data_byte};
		case (fill_q)
			2'd0:    padded = {in_data.data_byte, 24'h0};
			2'd1:    padded = {word_q[7:0], in_data.data_byte, 16'h0};
			2'd2:    padded = {word_q[15:0], in_data.data_byte, 8'h0};
			default: padded = full_word;
		endcase
		req_word = completes ? full_word : padded;
		if (completes) begin
			req_ndig = NDIG_FULL;
		end else if (in_data.end_of_message) begin
			req_ndig = {1'b0, fill_q} + 3'd2;
		end else begin
			req_ndig = 3'd0;
		end
		req_zero = completes && (full_word == 32'h0);
	end

	always_comb begin
		conv_push = conv_valid_q && (steps_q == 3'd0) && job_ready;
		conv_free = !conv_valid_q || conv_push;
		conv_step = conv_valid_q && (steps_q != 3'd0);
		in_ready  = !need_job || conv_free;
		accept    = in_valid && in_ready;
		load_conv = accept && need_job;
	end

	// one divide by 85 per cycle
	always_comb begin
		prod      = {32'h0, x_q} * {32'h0, RECIP85};
		quot      = prod[63:RECIP85_SHIFT];
		quot85_lo = 7'(quot[6:0] * RADIX);
		rem       = x_q[6:0] - quot85_lo;
		dig_idx   = 2'(steps_q - 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			inside_q <= 1'b0;
		end else if (accept) begin
			if (in_data.end_of_message) begin
				fill_q   <= 2'd0;
				inside_q <= 1'b0;
			end else begin
				fill_q   <= fill_q + 2'd1;
				inside_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= {word_q[15:0], in_data.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_valid_q <= 1'b0;
			steps_q      <= 3'd0;
		end else if (load_conv) begin
			conv_valid_q <= 1'b1;
			steps_q      <= ((req_ndig != 3'd0) && !req_zero) ? CONV_STEPS : 3'd0;
		end else if (conv_push) begin
			conv_valid_q <= 1'b0;
		end else if (conv_step) begin
			steps_q <= steps_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_conv) begin
			x_q          <= req_word;
			conv_open_q  <= open_req;
			conv_zero_q  <= req_zero;
			conv_ndig_q  <= req_ndig;
			conv_close_q <= in_data.end_of_message;
		end else if (conv_step) begin
			x_q              <= {6'h0, quot};
			dig_q[dig_idx]   <= rem;
		end
	end

	always_comb begin
		job_valid       = conv_valid_q && (steps_q == 3'd0);
		job.open_delim  = conv_open_q;
		job.zero_group  = conv_zero_q;
		job.ndig        = conv_ndig_q;
		job.close_delim = conv_close_q;
		// after four divides the quotient left over is the leading digit
		job.digits[0]   = x_q[6:0];
		for (int i = 1; i < DIGIT_COUNT; i++) begin
			job.digits[i] = dig_q[i-1];
		end
	end

endmodule
`default_nettype wire

/* src/a85_queue.sv */
`default_nettype none
module a85_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  a85_pkg::a85_job_t   push_data,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output a85_pkg::a85_job_t   pop_data
);
	import a85_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	a85_job_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		push_ready = (count_q != CW'(DEPTH));
		pop_valid  = (count_q != '0);
		pop_data   = mem_q[rd_ptr_q];
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* src/a85_back.sv */
`default_nettype none
module a85_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	output logic                job_ready,
	input  a85_pkg::a85_job_t   job,
	output logic                out_valid,
	input  wire                 out_ready,
	output a85_pkg::a85_out_t   out_data
);
	import a85_pkg::*;

	a85_emit_state_t state_q, state_d;
	a85_job_t        job_q;
	logic [2:0]      idx_q;
	logic            out_valid_q;
	a85_out_t        out_q;

	logic            slot_free, emit, body_done;
	logic [7:0]      char_d;
	logic            last_d;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		body_done = job_q.zero_group || (idx_q == 3'(job_q.ndig - 3'd1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EM_IDLE: begin
				if (job_valid) begin
					state_d = first_state(job);
				end
			end
			EM_OPEN0: begin
				if (slot_free) state_d = EM_OPEN1;
			end
			EM_OPEN1: begin
				if (slot_free) state_d = after_open(job_q);
			end
			EM_BODY: begin
				if (slot_free && body_done) state_d = after_body(job_q);
			end
			EM_CLOSE0: begin
				if (slot_free) state_d = EM_CLOSE1;
			end
			EM_CLOSE1: begin
				if (slot_free) state_d = EM_IDLE;
			end
			default: state_d = EM_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		emit      = 1'b0;
		char_d    = 8'h0;
		last_d    = 1'b0;
		unique case (state_q)
			EM_IDLE: begin
				job_ready = 1'b1;
			end
			EM_OPEN0: begin
				emit   = slot_free;
				char_d = CH_LT;
			end
			EM_OPEN1: begin
				emit   = slot_free;
				char_d = CH_TILDE;
			end
			EM_BODY: begin
				emit   = slot_free;
				char_d = job_q.zero_group ? CH_Z : ({1'b0, job_q.digits[idx_q]} + DIGIT_BIAS);
			end
			EM_CLOSE0: begin
				emit   = slot_free;
				char_d = CH_TILDE;
			end
			EM_CLOSE1: begin
				emit   = slot_free;
				char_d = CH_GT;
				last_d = 1'b1;
			end
			default: begin
				job_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (job_ready && job_valid) begin
				idx_q <= 3'd0;
			end else if (emit && (state_q == EM_BODY)) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_q <= job;
		end
		if (emit) begin
			out_q.text_char <= char_d;
			out_q.last_char <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* src/ascii85_encoder.sv */
// channel | direction | handshake               | beat payload
// input   | in        | in_valid / in_ready     | in_data: data_byte, end_of_message
// output  | out       | out_valid / out_ready   | out_data: text_char, last_char
//
// a byte that only extends a group is always taken; a byte that opens, closes or
// completes a group waits for a free base-85 converter, which divides by 85 as needed and
// hands its job on through the job queue to the emitter, which registers each character.
// the emitter gives one character per cycle while the output is not stalled, and goes
// through EM_IDLE to take each job.
// reset (arst_n low) empties the job queue and drops any partial group; output stalls back
// up through the job queue into the converter and input.
`default_nettype none
module ascii85_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  a85_pkg::a85_in_t    in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output a85_pkg::a85_out_t   out_data
);
	import a85_pkg::*;

	logic     fq_valid, fq_ready, qb_valid, qb_ready;
	a85_job_t fq_job, qb_job;

	a85_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	a85_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_job)
	);

	a85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* dv/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import a85_pkg::*;

	localparam int RAND_ITEMS = 305;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FILL_HOLD = 500;
	localparam int FILL_AT_BEAT = 200;
	localparam int DIR_COUNT = 25;

	// text is right-aligned ascii, leading zero bytes are unused
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        eom;
		logic        typed;
		logic [55:0] text;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	a85_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	a85_out_t out_data;

	// encoder state as seen by the predictor
	logic [31:0] grp_word = '0;
	int          grp_fill = 0;
	bit          in_msg = 1'b0;

	a85_out_t text_q[$];
	a85_out_t step_chars[$];
	int       errors = 0;
	int       cycles = 0;
	int       sent = 0;

	dir_row_t dir_rows [DIR_COUNT] = '{
		'{8'h00, 1'b1, 1'b1, "<~!!~>"},
		'{8'hFF, 1'b1, 1'b1, "<~rr~>"},
		'{8'h00, 1'b0, 1'b1, "<~"},
		'{8'h00, 1'b0, 1'b1, 56'd0},
		'{8'h00, 1'b0, 1'b1, 56'd0},
		'{8'h00, 1'b1, 1'b1, "z~>"},
		'{8'hFF, 1'b0, 1'b1, "<~"},
		'{8'hFF, 1'b0, 1'b1, 56'd0},
		'{8'hFF, 1'b0, 1'b1, 56'd0},
		'{8'hFF, 1'b1, 1'b1, "s8W-!~>"},
		'{8'h00, 1'b0, 1'b1, "<~"},
		'{8'h00, 1'b1, 1'b1, "!!!~>"},
		// zero partial group gets no z shortcut
		'{8'h00, 1'b0, 1'b1, "<~"},
		'{8'h00, 1'b0, 1'b1, 56'd0},
		'{8'h00, 1'b1, 1'b1, "!!!!~>"},
		'{8'h4D, 1'b0, 1'b0, 56'd0},
		'{8'h61, 1'b0, 1'b0, 56'd0},
		'{8'h6E, 1'b0, 1'b0, 56'd0},
		'{8'h20, 1'b0, 1'b0, 56'd0},
		'{8'hAA, 1'b1, 1'b0, 56'd0},
		'{8'h80, 1'b0, 1'b0, 56'd0},
		'{8'h01, 1'b0, 1'b0, 56'd0},
		'{8'h7F, 1'b1, 1'b0, 56'd0},
		'{8'h55, 1'b0, 1'b0, 56'd0},
		'{8'h01, 1'b1, 1'b0, 56'd0}
	};

	ascii85_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] base85_char(input logic [31:0] val, input int pos);
		logic [31:0] weight;
		case (pos)
			0: weight = 32'd52200625;
			1: weight = 32'd614125;
			2: weight = 32'd7225;
			3: weight = 32'd85;
			default: weight = 32'd1;
		endcase
		return 8'((val / weight) % 32'd85 + 32'd33);
	endfunction

	// fills step_chars with the characters one byte produces
	function automatic void encode_byte(input a85_in_t beat);
		logic [31:0] padded;
		step_chars.delete();
		if (!in_msg) begin
			step_chars.push_back({CH_LT, 1'b0});
			step_chars.push_back({CH_TILDE, 1'b0});
			in_msg = 1'b1;
		end
		grp_word = {grp_word[23:0], beat.data_byte};
		grp_fill++;
		if (grp_fill == 4) begin
			if (grp_word == 32'd0)
				step_chars.push_back({CH_Z, 1'b0});
			else
				for (int j = 0; j < 5; j++)
					step_chars.push_back({base85_char(grp_word, j), 1'b0});
			grp_word = '0;
			grp_fill = 0;
		end
		if (beat.end_of_message) begin
			if (grp_fill > 0) begin
				padded = grp_word << ((4 - grp_fill) * 8);
				for (int j = 0; j <= grp_fill; j++)
					step_chars.push_back({base85_char(padded, j), 1'b0});
			end
			step_chars.push_back({CH_TILDE, 1'b0});
			step_chars.push_back({CH_GT, 1'b1});
			grp_word = '0;
			grp_fill = 0;
			in_msg = 1'b0;
		end
	endfunction

	task automatic send_byte(input a85_in_t beat, input bit typed, input logic [55:0] text);
		int gap;
		logic [7:0] c;
		gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		sent++;
		encode_byte(beat);
		if (typed) begin
			for (int k = 6; k >= 0; k--) begin
				c = text[k*8 +: 8];
				if (c != 8'd0)
					text_q.push_back({c, 1'b0});
			end
			if (beat.end_of_message)
				text_q[text_q.size()-1].last_char = 1'b1;
		end else begin
			foreach (step_chars[i])
				text_q.push_back(step_chars[i]);
		end
	endtask

	// receiver: random stalls, one long hold to back the block up
	initial begin
		int gap;
		int beats;
		a85_out_t want;
		beats = 0;
		@(posedge arst_n);
		forever begin
			if (beats == FILL_AT_BEAT)
				gap = FILL_HOLD;
			else
				gap = ((beats / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats++;
			if (text_q.size() == 0) begin
				$error("unexpected beat: text_char %h last_char %b",
					out_data.text_char, out_data.last_char);
				errors++;
			end else begin
				want = text_q.pop_front();
				if (out_data.text_char !== want.text_char) begin
					$error("text_char: expected %h, got %h", want.text_char, out_data.text_char);
					errors++;
				end
				if (out_data.last_char !== want.last_char) begin
					$error("last_char: expected %b, got %b", want.last_char, out_data.last_char);
					errors++;
				end
			end
		end
	end

	initial begin
		a85_in_t beat;
		int      len;
		bit      zero_grp;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			beat.data_byte      = dir_rows[r].data_byte;
			beat.end_of_message = dir_rows[r].eom;
			send_byte(beat, dir_rows[r].typed, dir_rows[r].text);
		end

		// whole messages, some with all-zero groups and scattered 0xff bytes
		zero_grp = 1'b0;
		while (sent < DIR_COUNT + RAND_ITEMS) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 14);
			for (int i = 0; i < len; i++) begin
				if (i % 4 == 0)
					zero_grp = ($urandom_range(0, 4) == 0);
				if (zero_grp)
					beat.data_byte = 8'h00;
				else if ($urandom_range(0, 9) == 0)
					beat.data_byte = 8'hFF;
				else
					beat.data_byte = 8'($urandom);
				beat.end_of_message = (i == len - 1);
				send_byte(beat, 1'b0, 56'd0);
			end
		end
		in_valid <= 1'b0;

		while (text_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
